/* hdl/complementary_ahrs_tilt_compass_top_macros.svh */
// assertion macros used by the checker file
// each macro expands to one labeled concurrent assertion on i_clk, off in reset
`ifndef COMPLEMENTARY_AHRS_TILT_COMPASS_TOP_MACROS_SVH
`define COMPLEMENTARY_AHRS_TILT_COMPASS_TOP_MACROS_SVH

// same-cycle implication
`define CAHRS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cahrs check failed");

// next-cycle implication
`define CAHRS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cahrs check failed");

`endif

/* hdl/cahrs_pkg.sv */
// ----------------------------------------------------------------------------
// cahrs_pkg
// shared constants, types and the cordic arctangent table
// ----------------------------------------------------------------------------
package cahrs_pkg;

    localparam int ZW         = 28;   // angle width, 2^-16 degree
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [ZW-1:0] t_angle;

    localparam t_angle DEG90 = 28'sd5898240;
    localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [15:0] ANG_LIMIT = 16'sd23040;
    localparam logic [15:0] FULL_TURN = 16'd46080;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z  = 3'd4;

    // atan(2^-i) in 2^-16 degree
    function automatic t_angle atan_step(input logic [4:0] idx);
        t_angle v;
        unique case (idx)
            5'd0:  v = 28'sd2949120;
            5'd1:  v = 28'sd1740967;
            5'd2:  v = 28'sd919879;
            5'd3:  v = 28'sd466945;
            5'd4:  v = 28'sd234379;
            5'd5:  v = 28'sd117304;
            5'd6:  v = 28'sd58666;
            5'd7:  v = 28'sd29335;
            5'd8:  v = 28'sd14668;
            5'd9:  v = 28'sd7334;
            5'd10: v = 28'sd3667;
            5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;
            5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;
            5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;
            5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;
            5'd19: v = 28'sd7;
            5'd20: v = 28'sd4;
            5'd21: v = 28'sd2;
            5'd22: v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/cahrs_sample_if.sv */
// ----------------------------------------------------------------------------
// cahrs_sample_if
// eight-axis sample channel, valid/ready
// ----------------------------------------------------------------------------
interface cahrs_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic signed [15:0]             rate_x;
    logic signed [15:0]             rate_y;
    logic signed [SAMPLE_WIDTH-1:0] field_x;
    logic signed [SAMPLE_WIDTH-1:0] field_y;
    logic signed [SAMPLE_WIDTH-1:0] field_z;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, field_x, field_y, field_z,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, field_x, field_y, field_z,
        output ready
    );
endinterface

/* hdl/cahrs_result_if.sv */
// ----------------------------------------------------------------------------
// cahrs_result_if
// attitude and heading result channel, valid/ready
// ----------------------------------------------------------------------------
interface cahrs_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic [15:0]        heading;

    modport source (
        output valid, pitch_angle, roll_angle, heading,
        input  ready
    );
    modport sink (
        input  valid, pitch_angle, roll_angle, heading,
        output ready
    );
endinterface

/* hdl/complementary_ahrs_tilt_compass_top.sv */
// ----------------------------------------------------------------------------
// complementary_ahrs_tilt_compass_top
// complementary filter attitude with tilt compensated compass heading
// ----------------------------------------------------------------------------
// each beat runs the 32-step square root and five passes through the one cordic
// adder/shifter; no new beat is taken until the result of the last one is taken
// a zero-vector atan2 skips its cordic iterations
// input ready only while idle; the result register holds until its beat is taken
// reset (sync, active low): idle, pitch/roll state zero, registers at defaults
module complementary_ahrs_tilt_compass_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    cahrs_sample_if.sink                         i_sample,
    cahrs_result_if.source                       o_result,
    input  logic                                 i_cfg_we,
    input  logic [cahrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cahrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PRESHIFT = 32 - SAMPLE_WIDTH;          // scale samples up to 32 bits
    localparam int MW   = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1; // offset-corrected mag
    localparam int CW   = 60;                             // cordic x/y datapath
    localparam int MULW = 34;                             // shared multiplier operands
    localparam int IW   = $clog2(CORDIC_STEPS);
    localparam int ZW   = cahrs_pkg::ZW;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_ISQ, S_VSET,
        S_CINIT, S_CITER, S_CDONE,
        S_BL0, S_BL1, S_BL2, S_BL3, S_BL4,
        S_MG0, S_MG1, S_MG2, S_MG3, S_MG4, S_MG5, S_MG6, S_MG7,
        S_OUT
    } t_state;

    // which cordic job is running
    typedef enum logic [2:0] {
        PH_PITCH, PH_ROLL, PH_SINP, PH_SINR, PH_HEAD
    } t_phase;

    // configuration
    logic [15:0]        r_alpha;
    logic [15:0]        r_dt;
    logic signed [15:0] r_offx, r_offy, r_offz;

    // control
    t_state             r_state;
    t_phase             r_phase;
    logic               r_vec;      // vectoring (atan2) when set, else rotation (sin/cos)
    logic               r_neg;      // sin/cos angle was folded by 180 degrees
    logic               r_bsel;     // blend pass: 0 pitch, 1 roll
    logic [IW-1:0]      r_ci;

    // filter state
    logic signed [15:0] r_pitch, r_roll;

    // captured sample
    logic signed [SAMPLE_WIDTH-1:0] r_ax, r_ay, r_az;
    logic signed [15:0]             r_gx, r_gy;
    logic signed [MW-1:0]           r_mx, r_my, r_mz;

    // datapath
    logic signed [63:0]   r_acc, r_prod;
    logic [63:0]          r_root, r_bit;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic signed [ZW-1:0] r_pacc, r_racc;
    logic signed [MULW-1:0] r_sp, r_cp, r_sr, r_cr, r_t1, r_t2;
    logic [15:0]          r_head;

    // shared multiplier
    logic signed [MULW-1:0]   c_ma, c_mb;
    logic signed [2*MULW-1:0] c_prod;

    // shared cordic step
    logic signed [CW-1:0] c_xs, c_ys;
    logic signed [ZW-1:0] c_tab;
    logic                 c_ccw;

    logic [63:0]          c_try;
    logic signed [63:0]   c_blend;
    logic signed [15:0]   c_sat;
    logic signed [ZW:0]   c_hraw;
    logic [15:0]          c_head;
    logic signed [ZW-1:0] c_accang;
    logic signed [15:0]   c_store;
    logic signed [15:0]   c_rate;

    assign i_sample.ready       = (r_state == S_IDLE);
    assign o_result.valid       = (r_state == S_OUT);
    assign o_result.pitch_angle = r_pitch;
    assign o_result.roll_angle  = r_roll;
    assign o_result.heading     = r_head;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 16'd64225;
            r_dt    <= 16'd655;
            r_offx  <= '0;
            r_offy  <= '0;
            r_offz  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cahrs_pkg::REG_ALPHA:  r_alpha <= i_cfg_data;
                cahrs_pkg::REG_PERIOD: r_dt    <= i_cfg_data;
                cahrs_pkg::REG_OFF_X:  r_offx  <= $signed(i_cfg_data);
                cahrs_pkg::REG_OFF_Y:  r_offy  <= $signed(i_cfg_data);
                cahrs_pkg::REG_OFF_Z:  r_offz  <= $signed(i_cfg_data);
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // pick the blend operands of the current pass
    assign c_accang = r_bsel ? r_racc : r_pacc;
    assign c_store  = r_bsel ? r_roll : r_pitch;
    assign c_rate   = r_bsel ? r_gx   : r_gy;   // gyro x drives roll, y drives pitch

    // multiplier operand select
    always_comb begin
        c_ma = '0;
        c_mb = '0;
        unique case (r_state)
            S_SQ0: begin
                c_ma = MULW'(r_ay);
                c_mb = MULW'(r_ay);
            end
            S_SQ1: begin
                c_ma = MULW'(r_az);
                c_mb = MULW'(r_az);
            end
            S_BL0: begin
                c_ma = MULW'(c_rate);
                c_mb = MULW'($signed({1'b0, r_dt}));
            end
            S_BL2: begin
                c_ma = MULW'($signed({1'b0, r_alpha}));
                c_mb = r_acc[MULW-1:0];
            end
            S_BL3: begin
                c_ma = MULW'(18'sd65536 - $signed({2'b00, r_alpha}));
                c_mb = MULW'(c_accang) <<< 4;
            end
            S_MG0: begin
                c_ma = r_sr;
                c_mb = r_sp;
            end
            S_MG1: begin
                c_ma = r_cr;
                c_mb = r_sp;
            end
            S_MG2: begin
                c_ma = MULW'(r_mx);
                c_mb = r_cp;
            end
            S_MG3: begin
                c_ma = MULW'(r_my);
                c_mb = r_t1;
            end
            S_MG4: begin
                c_ma = MULW'(r_mz);
                c_mb = r_t2;
            end
            S_MG5: begin
                c_ma = MULW'(r_my);
                c_mb = r_cr;
            end
            S_MG6: begin
                c_ma = MULW'(r_mz);
                c_mb = r_sr;
            end
            default: ;
        endcase
    end

    assign c_prod = c_ma * c_mb;

    // cordic micro-rotation: ccw is x -= y>>i, y += x>>i, z -= atan
    assign c_xs  = r_cx >>> r_ci;
    assign c_ys  = r_cy >>> r_ci;
    assign c_tab = cahrs_pkg::atan_step(5'(r_ci));
    assign c_ccw = r_vec ? r_cy[CW-1] : ~r_cz[ZW-1];

    // square root trial subtrahend
    assign c_try = r_root + r_bit;

    // blend: round, scale down to 1/128 degree, clamp at +-180
    always_comb begin
        c_blend = (r_acc + r_prod + 64'sd268435456) >>> 29;
        if (c_blend > 64'sd23040)
            c_sat = cahrs_pkg::ANG_LIMIT;
        else if (c_blend < -64'sd23040)
            c_sat = -cahrs_pkg::ANG_LIMIT;
        else
            c_sat = c_blend[15:0];
    end

    // heading: round to 1/128 degree and wrap into 0..360
    always_comb begin
        c_hraw = ($signed({r_cz[ZW-1], r_cz}) + 29'sd256) >>> 9;
        if (c_hraw < 29'sd0)
            c_head = 16'(c_hraw + 29'sd46080);
        else if (c_hraw >= 29'sd46080)
            c_head = 16'(c_hraw - 29'sd46080);
        else
            c_head = c_hraw[15:0];
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_PITCH;
            r_vec   <= 1'b1;
            r_neg   <= 1'b0;
            r_bsel  <= 1'b0;
            r_ci    <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_ax    <= i_sample.accel_x;
                        r_ay    <= i_sample.accel_y;
                        r_az    <= i_sample.accel_z;
                        r_gx    <= i_sample.rate_x;
                        r_gy    <= i_sample.rate_y;
                        r_mx    <= MW'(i_sample.field_x) - MW'(r_offx);
                        r_my    <= MW'(i_sample.field_y) - MW'(r_offy);
                        r_mz    <= MW'(i_sample.field_z) - MW'(r_offz);
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0: begin
                    r_prod  <= c_prod[63:0];
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_acc   <= r_prod;
                    r_prod  <= c_prod[63:0];
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    // ay^2 + az^2 scaled to the 32-bit sample range
                    r_acc   <= (r_acc + r_prod) <<< (2 * PRESHIFT);
                    r_root  <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_state <= S_ISQ;
                end
                S_ISQ: begin
                    // one result bit per cycle
                    if ($unsigned(r_acc) >= c_try) begin
                        r_acc  <= $signed($unsigned(r_acc) - c_try);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0])
                        r_state <= S_VSET;
                end
                S_VSET: begin
                    // accelerometer pitch: atan2(-ax, hypot(ay, az))
                    r_cx    <= $signed({1'b0, r_root[CW-2:0]});
                    r_cy    <= -(CW'(r_ax) <<< PRESHIFT);
                    r_vec   <= 1'b1;
                    r_phase <= PH_PITCH;
                    r_state <= S_CINIT;
                end
                S_CINIT: begin
                    r_ci <= '0;
                    if (r_vec) begin
                        if (r_cx == '0 && r_cy == '0) begin
                            // atan2 of the zero vector is zero
                            r_cz    <= '0;
                            r_state <= S_CDONE;
                        end else begin
                            // fold the left half plane by 90 degrees
                            if (r_cx[CW-1]) begin
                                if (!r_cy[CW-1]) begin
                                    r_cx <= r_cy;
                                    r_cy <= -r_cx;
                                    r_cz <= cahrs_pkg::DEG90;
                                end else begin
                                    r_cx <= -r_cy;
                                    r_cy <= r_cx;
                                    r_cz <= -cahrs_pkg::DEG90;
                                end
                            end else begin
                                r_cz <= '0;
                            end
                            r_state <= S_CITER;
                        end
                    end else begin
                        // fold the angle into +-90, negate sin/cos afterwards
                        if (r_cz > cahrs_pkg::DEG90) begin
                            r_cz  <= r_cz - (cahrs_pkg::DEG90 <<< 1);
                            r_neg <= 1'b1;
                        end else if (r_cz < -cahrs_pkg::DEG90) begin
                            r_cz  <= r_cz + (cahrs_pkg::DEG90 <<< 1);
                            r_neg <= 1'b1;
                        end else begin
                            r_neg <= 1'b0;
                        end
                        r_cx    <= CW'(cahrs_pkg::GAIN_INV);
                        r_cy    <= '0;
                        r_state <= S_CITER;
                    end
                end
                S_CITER: begin
                    if (c_ccw) begin
                        r_cx <= r_cx - c_ys;
                        r_cy <= r_cy + c_xs;
                        r_cz <= r_cz - c_tab;
                    end else begin
                        r_cx <= r_cx + c_ys;
                        r_cy <= r_cy - c_xs;
                        r_cz <= r_cz + c_tab;
                    end
                    if (r_ci == IW'(CORDIC_STEPS - 1))
                        r_state <= S_CDONE;
                    else
                        r_ci <= r_ci + 1'b1;
                end
                S_CDONE: begin
                    unique case (r_phase)
                        PH_PITCH: begin
                            // accelerometer roll: atan2(ay, az)
                            r_pacc  <= r_cz;
                            r_cx    <= CW'(r_az) <<< PRESHIFT;
                            r_cy    <= CW'(r_ay) <<< PRESHIFT;
                            r_phase <= PH_ROLL;
                            r_state <= S_CINIT;
                        end
                        PH_ROLL: begin
                            r_racc  <= r_cz;
                            r_bsel  <= 1'b0;
                            r_state <= S_BL0;
                        end
                        PH_SINP: begin
                            r_sp    <= r_neg ? -r_cy[MULW-1:0] : r_cy[MULW-1:0];
                            r_cp    <= r_neg ? -r_cx[MULW-1:0] : r_cx[MULW-1:0];
                            r_cz    <= ZW'(r_roll) <<< 9;
                            r_phase <= PH_SINR;
                            r_state <= S_CINIT;
                        end
                        PH_SINR: begin
                            r_sr    <= r_neg ? -r_cy[MULW-1:0] : r_cy[MULW-1:0];
                            r_cr    <= r_neg ? -r_cx[MULW-1:0] : r_cx[MULW-1:0];
                            r_state <= S_MG0;
                        end
                        PH_HEAD: begin
                            r_head  <= c_head;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                // complementary blend, pitch pass then roll pass
                S_BL0: begin
                    r_prod  <= c_prod[63:0];                    // rate * dt
                    r_state <= S_BL1;
                end
                S_BL1: begin
                    r_acc   <= (64'(c_store) <<< 13) + r_prod;  // gyro-integrated angle
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    r_prod  <= c_prod[63:0];                    // alpha * gyro angle
                    r_state <= S_BL3;
                end
                S_BL3: begin
                    r_acc   <= r_prod;
                    r_prod  <= c_prod[63:0];                    // (1 - alpha) * accel angle
                    r_state <= S_BL4;
                end
                S_BL4: begin
                    if (!r_bsel) begin
                        r_pitch <= c_sat;
                        r_bsel  <= 1'b1;
                        r_state <= S_BL0;
                    end else begin
                        r_roll  <= c_sat;
                        r_cz    <= ZW'(r_pitch) <<< 9;
                        r_vec   <= 1'b0;
                        r_phase <= PH_SINP;
                        r_state <= S_CINIT;
                    end
                end
                // tilt compensation of the magnetometer
                S_MG0: begin
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG1;
                end
                S_MG1: begin
                    r_t1    <= MULW'(r_prod >>> 30);            // sin(roll) * sin(pitch)
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG2;
                end
                S_MG2: begin
                    r_t2    <= MULW'(r_prod >>> 30);            // cos(roll) * sin(pitch)
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG3;
                end
                S_MG3: begin
                    r_acc   <= r_prod;
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG4;
                end
                S_MG4: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG5;
                end
                S_MG5: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG6;
                end
                S_MG6: begin
                    r_cx    <= r_acc[CW-1:0];                   // horizontal x
                    r_acc   <= r_prod;
                    r_prod  <= c_prod[63:0];
                    r_state <= S_MG7;
                end
                S_MG7: begin
                    r_cy    <= CW'(r_acc - r_prod);             // horizontal y
                    r_vec   <= 1'b1;
                    r_phase <= PH_HEAD;
                    r_state <= S_CINIT;
                end
                S_OUT: begin
                    if (o_result.ready)
                        r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/cahrs_checker.sv */
// ----------------------------------------------------------------------------
// cahrs_checker
// port-level checks on the attitude and heading block
// ----------------------------------------------------------------------------
`include "complementary_ahrs_tilt_compass_top_macros.svh"

module cahrs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_pitch,
    input logic signed [15:0] i_roll,
    input logic [15:0]        i_heading
);

    // one item at a time: no new beat while a result is pending
    `CAHRS_ASSERT_IMPL(a_no_overlap, i_in_valid && i_in_ready, !i_out_valid)

    // a taken result is not shown twice
    `CAHRS_ASSERT_NEXT(a_single_beat, i_out_valid && i_out_ready, !i_out_valid)

    // clamped angles
    `CAHRS_ASSERT_IMPL(a_angle_range, i_out_valid, i_pitch >= -cahrs_pkg::ANG_LIMIT && i_pitch <= cahrs_pkg::ANG_LIMIT && i_roll >= -cahrs_pkg::ANG_LIMIT && i_roll <= cahrs_pkg::ANG_LIMIT)

    // heading wrapped below a full turn
    `CAHRS_ASSERT_IMPL(a_heading_range, i_out_valid, i_heading < cahrs_pkg::FULL_TURN)

    // stalled result holds
    `CAHRS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_heading) && $stable(i_pitch) && $stable(i_roll))

endmodule

bind complementary_ahrs_tilt_compass_top cahrs_checker u_cahrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_pitch     (o_result.pitch_angle),
    .i_roll      (o_result.roll_angle),
    .i_heading   (o_result.heading)
);

/* tb/tb_cahrs_checker.sv */
// ----------------------------------------------------------------------------
// tb_cahrs_checker
// watches the sample and result channels, predicts attitude and heading
// from its own fixed point model and compares every result beat
// ----------------------------------------------------------------------------
module tb_cahrs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cahrs_sample_if                             i_sample,
    cahrs_result_if                             i_result,
    input  logic                                i_cfg_we,
    input  logic [cahrs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cahrs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic [15:0]        heading;
    } t_attitude;

    t_attitude         attitude_q[$];
    logic [15:0]       alpha_r;
    logic [15:0]       period_r;
    longint            off_x, off_y, off_z;
    longint            pitch_st, roll_st;

    localparam longint ARC [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = cahrs_pkg::DEG90;
            end else begin
                t = x; x = -y; y = t; z = -cahrs_pkg::DEG90;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ARC[i];
            end else begin
                x -= ys; y += xs; z -= ARC[i];
            end
        end
        return z;
    endfunction

    task automatic rotate(input longint a, output longint s, output longint c);
        longint x, y, xs, ys;
        bit neg;
        x = cahrs_pkg::GAIN_INV;
        y = 0;
        neg = 0;
        if (a > cahrs_pkg::DEG90) begin
            a -= 2 * cahrs_pkg::DEG90; neg = 1;
        end else if (a < -cahrs_pkg::DEG90) begin
            a += 2 * cahrs_pkg::DEG90; neg = 1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (a >= 0) begin
                x -= ys; y += xs; a -= ARC[i];
            end else begin
                x += ys; y -= xs; a += ARC[i];
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic longint mix(longint ang, longint rate, longint acc);
        longint g, a, al, v;
        g = ang * 8192 + rate * longint'(period_r);
        a = acc * 16;
        al = longint'(alpha_r);
        v = (al * g + (65536 - al) * a + (64'sd1 <<< 28)) >>> 29;
        if (v > cahrs_pkg::ANG_LIMIT) v = cahrs_pkg::ANG_LIMIT;
        if (v < -cahrs_pkg::ANG_LIMIT) v = -cahrs_pkg::ANG_LIMIT;
        return v;
    endfunction

    task automatic predict_attitude();
        longint ax, ay, az, mx, my, mz, hyp, pa, ra, sp, cp, sr, cr, xh, yh, h;
        t_attitude e;
        ax = i_sample.accel_x;
        ay = i_sample.accel_y;
        az = i_sample.accel_z;
        mx = longint'(i_sample.field_x) - off_x;
        my = longint'(i_sample.field_y) - off_y;
        mz = longint'(i_sample.field_z) - off_z;
        hyp = isqrt((ay * ay + az * az) << 32);
        pa = vec_angle(-ax * 65536, hyp);
        ra = vec_angle(ay * 65536, az * 65536);
        pitch_st = mix(pitch_st, longint'(i_sample.rate_y), pa);
        roll_st = mix(roll_st, longint'(i_sample.rate_x), ra);
        rotate(pitch_st * 512, sp, cp);
        rotate(roll_st * 512, sr, cr);
        xh = mx * cp + my * ((sr * sp) >>> 30) + mz * ((cr * sp) >>> 30);
        yh = my * cr - mz * sr;
        h = (vec_angle(yh, xh) + 256) >>> 9;
        if (h < 0) h += cahrs_pkg::FULL_TURN;
        if (h >= cahrs_pkg::FULL_TURN) h -= cahrs_pkg::FULL_TURN;
        e.pitch = pitch_st[15:0];
        e.roll = roll_st[15:0];
        e.heading = h[15:0];
        attitude_q.push_back(e);
    endtask

    assign o_pending = attitude_q.size();

    always @(posedge i_clk) begin
        t_attitude e;
        if (!i_rst_n) begin
            alpha_r <= 16'd64225;
            period_r <= 16'd655;
            off_x = 0; off_y = 0; off_z = 0;
            pitch_st = 0; roll_st = 0;
            o_fail_count <= 0;
            attitude_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cahrs_pkg::REG_ALPHA:  alpha_r <= i_cfg_data;
                    cahrs_pkg::REG_PERIOD: period_r <= i_cfg_data;
                    cahrs_pkg::REG_OFF_X:  off_x = $signed(i_cfg_data);
                    cahrs_pkg::REG_OFF_Y:  off_y = $signed(i_cfg_data);
                    cahrs_pkg::REG_OFF_Z:  off_z = $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready) predict_attitude();
            if (i_result.valid && i_result.ready) begin
                if (attitude_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %0d %0d %0d", $time,
                             i_result.pitch_angle, i_result.roll_angle, i_result.heading);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = attitude_q.pop_front();
                    if (e.pitch !== i_result.pitch_angle || e.roll !== i_result.roll_angle
                        || e.heading !== i_result.heading) begin
                        $display("%0t: expected %0d %0d %0d, actual %0d %0d %0d", $time,
                                 e.pitch, e.roll, e.heading, i_result.pitch_angle,
                                 i_result.roll_angle, i_result.heading);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_complementary_ahrs_tilt_compass_top.sv */
// ----------------------------------------------------------------------------
// tb_complementary_ahrs_tilt_compass_top
// drives samples and register writes with random gaps and result stalls;
// the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_complementary_ahrs_tilt_compass_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              cfg_we;
    logic [cahrs_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [cahrs_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                                fail_count;
    int                                pending;
    int                                cycle_count;

    cahrs_sample_if #(.SAMPLE_WIDTH(16)) sample_ch ();
    cahrs_result_if result_ch ();

    complementary_ahrs_tilt_compass_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(sample_ch), .o_result(result_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    tb_cahrs_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(sample_ch), .i_result(result_ch),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // run limit: ~1120 beats plus stalls, with margin
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side stalls: random gap of ready low per beat
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // one sample beat, gap drawn first, then hold until accepted
    task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, mx, my, mz);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_ch.accel_x <= ax; sample_ch.accel_y <= ay; sample_ch.accel_z <= az;
        sample_ch.rate_x <= gx; sample_ch.rate_y <= gy;
        sample_ch.field_x <= mx; sample_ch.field_y <= my; sample_ch.field_z <= mz;
        sample_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [15:0] v [8];
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 5))
                0: v[k] = 16'h8000;
                1: v[k] = 16'h7fff;
                2: v[k] = 16'h0000;
                3: v[k] = 16'($signed($urandom_range(0, 800)) - 400);
                default: v[k] = 16'($urandom);
            endcase
        end
        send_sample(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    // settle, then write a register at an idle block
    task automatic write_reg(input logic [cahrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        sample_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (160) @(negedge i_clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = '0; sample_ch.accel_y = '0; sample_ch.accel_z = '0;
        sample_ch.rate_x = '0; sample_ch.rate_y = '0;
        sample_ch.field_x = '0; sample_ch.field_y = '0; sample_ch.field_z = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero vectors, extremes, saturating rates, quadrant corners
        send_sample('0, '0, '0, '0, '0, '0, '0, '0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h8000, 16'h8000, 16'h8000);
        send_sample('0, '0, 16'd4096, '0, '0, 16'd300, '0, '0);
        send_sample('0, '0, 16'hf000, '0, '0, 16'hfe00, 16'h0100, '0);
        send_sample(16'd4096, '0, '0, '0, '0, '0, 16'hff00, 16'd200);
        send_sample('0, 16'hf000, '0, '0, '0, 16'hff00, 16'hff00, 16'hff00);

        // gyro only: push angles into the clamp at both ends
        write_reg(cahrs_pkg::REG_ALPHA, 16'hffff);
        write_reg(cahrs_pkg::REG_PERIOD, 16'hffff);
        repeat (4) send_sample('0, '0, 16'd100, 16'h7fff, 16'h7fff, 16'd50, 16'd10, '0);
        repeat (4) send_sample('0, '0, 16'd100, 16'h8000, 16'h8000, 16'd50, 16'd10, '0);
        // zero sample period, accelerometer only
        write_reg(cahrs_pkg::REG_PERIOD, 16'h0000);
        write_reg(cahrs_pkg::REG_ALPHA, 16'h0000);
        write_reg(cahrs_pkg::REG_OFF_X, 16'h7fff);
        write_reg(cahrs_pkg::REG_OFF_Y, 16'h8000);
        write_reg(cahrs_pkg::REG_OFF_Z, 16'h1234);
        write_reg(3'd7, 16'hbeef);
        repeat (5) send_random();

        // random phases, each with fresh register settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(cahrs_pkg::REG_ALPHA, (ph % 3 == 0) ? 16'd64225 : 16'($urandom));
            write_reg(cahrs_pkg::REG_PERIOD, (ph % 4 == 1) ? 16'd1 : 16'($urandom));
            write_reg(cahrs_pkg::REG_OFF_X, 16'($urandom));
            write_reg(cahrs_pkg::REG_OFF_Y, 16'($urandom));
            write_reg(cahrs_pkg::REG_OFF_Z, (ph == 9) ? 16'h0000 : 16'($urandom));
            repeat (110) send_random();
        end

        sample_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
